FILE: hw/rtl/fdc_pkg.sv
// Shared constants and controller/datapath interface types of the FIR convolution core.
package fdc_pkg;

  localparam int unsigned MAX_TAPS    = 64;
  localparam int unsigned SAMPLE_BITS = 16;

  localparam int unsigned FRAC_BITS   = SAMPLE_BITS - 1;
  localparam int unsigned IDX_W       = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int unsigned CNT_W       = $clog2(MAX_TAPS + 1);
  localparam int unsigned PROD_W      = 2 * SAMPLE_BITS;
  localparam int unsigned ACC_W       = PROD_W + IDX_W;

  localparam int unsigned TAP_CNT_W   = 7;
  localparam int unsigned COEF_IDX_W  = 6;
  localparam logic [TAP_CNT_W-1:0] TAP_CNT_RESET = TAP_CNT_W'(64);

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_COEF   = 1'b1;

  typedef struct packed {
    logic             sample_start;
    logic             coef_wr;
    logic             issue;
    logic [IDX_W-1:0] tap_idx;
    logic             finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

FILE: hw/rtl/fir_direct_convolution_core.sv
// Top level of the direct-form FIR convolution core.
// A coefficient transfer is written at acceptance and yields no result; a sample transfer
// steps through N taps, then drain, accumulate and done, into the output register; N is
// the tap count in use (capped at the store depth), since one shared multiply-accumulate
// unit reads one tap per cycle from the delay-line and coefficient RAMs.
// One coefficient is taken every cycle while idle; no item is taken while a sample is in
// progress, and a sample takes longer while the previous result waits on a stalled output.
// Reset is asynchronous and active low; it empties both stores (via per-entry valid bits)
// and the output register, and sets the tap count to 64. No clearing pass is needed.
module fir_direct_convolution_core (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // Input item channel.
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic                                   req_type_i,
  input  logic signed [fdc_pkg::SAMPLE_BITS-1:0] sample_in_i,
  input  logic [fdc_pkg::COEF_IDX_W-1:0]         coef_index_i,
  input  logic signed [fdc_pkg::SAMPLE_BITS-1:0] coef_value_i,
  // Result channel.
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [fdc_pkg::SAMPLE_BITS-1:0] sample_out_o,
  // Tap count register write channel.
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [fdc_pkg::TAP_CNT_W-1:0]          cfg_tap_count_i
);

  // The controller accepts one item at a time. A coefficient transfer is written into
  // the coefficient RAM directly at acceptance. A sample transfer is written into the
  // delay line at the newest position, then the controller steps a tap index through
  // the taps while the datapath reads both RAMs, multiplies and accumulates.
  fdc_pkg::ctrl_cmd_t  cmd;
  fdc_pkg::dp_status_t status;

  fdc_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .req_type_i      (req_type_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_tap_count_i (cfg_tap_count_i),
    .cmd_o           (cmd),
    .status_i        (status)
  );

  // The datapath keeps the finished result in its output register, so a new item is
  // taken while an earlier result still waits; the controller holds only the final
  // load step until that register is free.
  fdc_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .sample_in_i  (sample_in_i),
    .coef_index_i (coef_index_i),
    .coef_value_i (coef_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sample_out_o (sample_out_o)
  );

endmodule

FILE: hw/rtl/fdc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module fdc_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 64
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(Depth > 1 ? Depth : 2)-1:0] waddr_i,
  input  logic [Width-1:0]                 wdata_i,
  input  logic                             re_i,
  input  logic [$clog2(Depth > 1 ? Depth : 2)-1:0] raddr_i,
  output logic [Width-1:0]                 rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/fdc_ctrl.sv
// Sequencing state machine of the FIR convolution core.
module fdc_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          req_type_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [fdc_pkg::TAP_CNT_W-1:0] cfg_tap_count_i,
  output fdc_pkg::ctrl_cmd_t            cmd_o,
  input  fdc_pkg::dp_status_t           status_i
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StRun   = 3'd1;
  localparam logic [2:0] StDrain = 3'd2;
  localparam logic [2:0] StAcc   = 3'd3;
  localparam logic [2:0] StDone  = 3'd4;

  logic [2:0]                    state_q, state_d;
  logic [fdc_pkg::CNT_W-1:0]     cnt_q, cnt_d;
  logic [fdc_pkg::TAP_CNT_W-1:0] tap_count_q;
  logic [fdc_pkg::CNT_W-1:0]     taps_used;
  logic                          accept;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != StIdle);
  assign accept      = in_valid_i && !in_stall_o;

  // A tap count above the store depth runs over the whole store.
  always_comb begin
    if (int'(tap_count_q) > int'(fdc_pkg::MAX_TAPS)) begin
      taps_used = fdc_pkg::CNT_W'(fdc_pkg::MAX_TAPS);
    end else begin
      taps_used = fdc_pkg::CNT_W'(tap_count_q);
    end
  end

  always_comb begin
    state_d              = state_q;
    cnt_d                = cnt_q;
    cmd_o.sample_start   = 1'b0;
    cmd_o.coef_wr        = 1'b0;
    cmd_o.issue          = 1'b0;
    cmd_o.tap_idx        = cnt_q[fdc_pkg::IDX_W-1:0];
    cmd_o.finish         = 1'b0;
    case (state_q)
      StIdle: begin
        if (accept) begin
          if (req_type_i == fdc_pkg::REQ_COEF) begin
            cmd_o.coef_wr = 1'b1;
          end else begin
            cmd_o.sample_start = 1'b1;
            cnt_d              = '0;
            state_d            = (taps_used == '0) ? StDrain : StRun;
          end
        end
      end
      StRun: begin
        cmd_o.issue = 1'b1;
        cnt_d       = cnt_q + 1'b1;
        if (cnt_q + 1'b1 == taps_used) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        state_d = StAcc;
      end
      StAcc: begin
        state_d = StDone;
      end
      StDone: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      tap_count_q <= fdc_pkg::TAP_CNT_RESET;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_valid_i && cfg_ready_o) begin
        tap_count_q <= cfg_tap_count_i;
      end
    end
  end

endmodule

FILE: hw/rtl/fdc_dp.sv
// Datapath of the FIR convolution core: stores, multiply-accumulate and output register.
module fdc_dp (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  fdc_pkg::ctrl_cmd_t                    cmd_i,
  output fdc_pkg::dp_status_t                   status_o,
  input  logic signed [fdc_pkg::SAMPLE_BITS-1:0] sample_in_i,
  input  logic [fdc_pkg::COEF_IDX_W-1:0]         coef_index_i,
  input  logic signed [fdc_pkg::SAMPLE_BITS-1:0] coef_value_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [fdc_pkg::SAMPLE_BITS-1:0] sample_out_o
);

  localparam int unsigned SB    = fdc_pkg::SAMPLE_BITS;
  localparam int unsigned IW    = fdc_pkg::IDX_W;
  localparam int unsigned AW    = fdc_pkg::ACC_W;
  localparam int unsigned PW    = fdc_pkg::PROD_W;
  localparam int unsigned Depth = fdc_pkg::MAX_TAPS;

  localparam logic signed [AW-1:0] SatHi = {{(AW-SB+1){1'b0}}, {(SB-1){1'b1}}};
  localparam logic signed [AW-1:0] SatLo = ~SatHi;

  logic [IW-1:0]          pos_q;
  logic [Depth-1:0]       dly_vld_q;
  logic [Depth-1:0]       coef_vld_q;
  logic [IW:0]            addr_sum;
  logic [IW-1:0]          dly_raddr;
  logic [IW-1:0]          coef_waddr;
  logic                   coef_in_range;
  logic [SB-1:0]          dly_rdata;
  logic [SB-1:0]          coef_rdata;
  logic                   rd_vld_q;
  logic                   dly_ok_q;
  logic                   coef_ok_q;
  logic signed [SB-1:0]   op_x;
  logic signed [SB-1:0]   op_h;
  logic                   prod_vld_q;
  logic signed [PW-1:0]   prod_q;
  logic signed [AW-1:0]   acc_q;
  logic signed [AW-1:0]   shifted;
  logic signed [SB-1:0]   sat;
  logic                   out_valid_q;
  logic signed [SB-1:0]   out_q;

  // Slot of x[n-i] is the newest position plus the tap index, modulo the depth.
  assign addr_sum = {1'b0, pos_q} + {1'b0, cmd_i.tap_idx};
  always_comb begin
    if (int'(addr_sum) >= int'(Depth)) begin
      dly_raddr = IW'(int'(addr_sum) - int'(Depth));
    end else begin
      dly_raddr = addr_sum[IW-1:0];
    end
  end

  assign coef_waddr    = IW'(coef_index_i);
  assign coef_in_range = int'(coef_index_i) < int'(Depth);

  fdc_ram #(.Width(SB), .Depth(Depth)) u_dly_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.sample_start),
    .waddr_i (pos_q),
    .wdata_i (sample_in_i),
    .re_i    (cmd_i.issue),
    .raddr_i (dly_raddr),
    .rdata_o (dly_rdata)
  );

  fdc_ram #(.Width(SB), .Depth(Depth)) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.coef_wr && coef_in_range),
    .waddr_i (coef_waddr),
    .wdata_i (coef_value_i),
    .re_i    (cmd_i.issue),
    .raddr_i (cmd_i.tap_idx),
    .rdata_o (coef_rdata)
  );

  // Entries never written since reset read as zero.
  assign op_x = dly_ok_q  ? $signed(dly_rdata)  : '0;
  assign op_h = coef_ok_q ? $signed(coef_rdata) : '0;

  assign shifted = acc_q >>> fdc_pkg::FRAC_BITS;
  always_comb begin
    if (shifted > SatHi) begin
      sat = SatHi[SB-1:0];
    end else if (shifted < SatLo) begin
      sat = SatLo[SB-1:0];
    end else begin
      sat = shifted[SB-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      dly_vld_q   <= '0;
      coef_vld_q  <= '0;
      rd_vld_q    <= 1'b0;
      prod_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_vld_q   <= cmd_i.issue;
      prod_vld_q <= rd_vld_q;
      if (cmd_i.sample_start) begin
        dly_vld_q[pos_q] <= 1'b1;
      end
      if (cmd_i.coef_wr && coef_in_range) begin
        coef_vld_q[coef_waddr] <= 1'b1;
      end
      if (cmd_i.finish) begin
        pos_q       <= (pos_q == '0) ? IW'(Depth - 1) : pos_q - 1'b1;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      dly_ok_q  <= dly_vld_q[dly_raddr];
      coef_ok_q <= coef_vld_q[cmd_i.tap_idx];
    end
    if (rd_vld_q) begin
      prod_q <= op_x * op_h;
    end
    if (cmd_i.sample_start) begin
      acc_q <= '0;
    end else if (prod_vld_q) begin
      acc_q <= acc_q + {{(AW-PW){prod_q[PW-1]}}, prod_q};
    end
    if (cmd_i.finish) begin
      out_q <= sat;
    end
  end

  assign status_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o       = out_valid_q;
  assign sample_out_o      = out_q;

endmodule
